/* hdl/swg_pkg.sv */
// ----------------------------------------------------------------------------
// swg_pkg: shared definitions for the sawtooth/triangle wave generator
// Widths, register map, reset values and sequencer states.
// ----------------------------------------------------------------------------
package swg_pkg;

    // Output and phase widths
    localparam int DAC_BITS   = 12;
    localparam int PHASE_BITS = 16;
    localparam int VREF_MV    = 5000;
    localparam int DAC_MAX    = (1 << DAC_BITS) - 1;

    // Configuration field widths
    localparam int MODE_W   = 1;
    localparam int TICKS_W  = 16;
    localparam int AMP_W    = 14;
    localparam int OFFS_W   = 15;

    // Datapath widths
    localparam int OP_W     = 18;                  // shared multiplier operand
    localparam int PROD_W   = 2 * OP_W;            // product and accumulator
    localparam int DIV_W    = 29;                  // VREF_MV * 65535 fits here
    localparam int REM_W    = DIV_W + DAC_BITS;    // scaled numerator
    localparam int CNT_W    = $clog2(DAC_BITS);

    // APB
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    // Register index within the map (byte address = 4 * index)
    typedef enum logic [2:0] {
        REG_WAVE_MODE    = 3'd0,
        REG_PERIOD_TICKS = 3'd1,
        REG_AMPLITUDE_MV = 3'd2,
        REG_OFFSET_MV    = 3'd3,
        REG_RISE_TICKS   = 3'd4,
        REG_FALL_TICKS   = 3'd5
    } reg_idx_t;

    // Reset values
    localparam logic [MODE_W-1:0]  RST_WAVE_MODE = '0;
    localparam logic [TICKS_W-1:0] RST_PERIOD    = 16'd3000;
    localparam logic [AMP_W-1:0]   RST_AMPLITUDE = 14'd3000;
    localparam logic [OFFS_W-1:0]  RST_OFFSET    = 15'd1000;
    localparam logic [TICKS_W-1:0] RST_RISE      = 16'd1500;
    localparam logic [TICKS_W-1:0] RST_FALL      = 16'd1500;

    localparam logic [MODE_W-1:0]  MODE_SAWTOOTH = 1'b0;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_C,
        ST_CHECK,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

/* hdl/sawtooth_triangle_wave_generator.sv */
// ----------------------------------------------------------------------------
// sawtooth_triangle_wave_generator
// Phase counter, waveform evaluation and DAC scaling with one shared
// multiplier and a bit-serial divider under a small sequencer.
// ----------------------------------------------------------------------------
// Each accepted item with tick = 1 advances the phase counter (which wraps to
// 1 beyond period_ticks) and yields exactly one result: the waveform value in
// mV, clamped to 0..5000 mV and scaled to a DAC code by truncation, plus a
// clamped flag. A tick = 0 item leaves the block idle and yields nothing.
// An in-range sample occupies the block from acceptance until the next one: a
// setup step, three passes through the shared 18x18 multiplier, one range
// check, DAC_BITS (12) restoring divide steps and the hand-off to the output
// register, which waits out an output stall. A clamped sample skips the
// divider. The output register holds a finished result while the next item is
// accepted and worked on. Configuration is to be written over APB (byte
// addresses 0, 4, ... 20) only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module sawtooth_triangle_wave_generator (
    input  logic                        clk,
    input  logic                        rst_n,
    // input items
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        tick,
    // result items
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [swg_pkg::DAC_BITS-1:0] dac_code,
    output logic                        clamped,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [swg_pkg::ADDR_W-1:0]  paddr,
    input  logic [swg_pkg::DATA_W-1:0]  pwdata,
    output logic [swg_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import swg_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [MODE_W-1:0]  wave_mode_reg;
    logic [TICKS_W-1:0] period_reg;
    logic [AMP_W-1:0]   amplitude_reg;
    logic [OFFS_W-1:0]  offset_reg;
    logic [TICKS_W-1:0] rise_reg;
    logic [TICKS_W-1:0] fall_reg;

    reg_idx_t cfg_idx;
    logic     cfg_wr;

    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_mode_reg <= RST_WAVE_MODE;
            period_reg    <= RST_PERIOD;
            amplitude_reg <= RST_AMPLITUDE;
            offset_reg    <= RST_OFFSET;
            rise_reg      <= RST_RISE;
            fall_reg      <= RST_FALL;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_WAVE_MODE:    wave_mode_reg <= pwdata[MODE_W-1:0];
                REG_PERIOD_TICKS: period_reg    <= pwdata[TICKS_W-1:0];
                REG_AMPLITUDE_MV: amplitude_reg <= pwdata[AMP_W-1:0];
                REG_OFFSET_MV:    offset_reg    <= pwdata[OFFS_W-1:0];
                REG_RISE_TICKS:   rise_reg      <= pwdata[TICKS_W-1:0];
                REG_FALL_TICKS:   fall_reg      <= pwdata[TICKS_W-1:0];
                default:          ;   // unmapped addresses ignored
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_WAVE_MODE:    prdata = DATA_W'(wave_mode_reg);
            REG_PERIOD_TICKS: prdata = DATA_W'(period_reg);
            REG_AMPLITUDE_MV: prdata = DATA_W'(amplitude_reg);
            REG_OFFSET_MV:    prdata = {{(DATA_W-OFFS_W){offset_reg[OFFS_W-1]}}, offset_reg};
            REG_RISE_TICKS:   prdata = DATA_W'(rise_reg);
            REG_FALL_TICKS:   prdata = DATA_W'(fall_reg);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer and datapath registers
    // ------------------------------------------------------------------
    state_t                    state_reg, state_next;
    logic [PHASE_BITS-1:0]     phase_reg, phase_next;
    logic signed [OP_W-1:0]    x0_reg, x0_next, y0_reg, y0_next;
    logic signed [OP_W-1:0]    x1_reg, x1_next, y1_reg, y1_next;
    logic                      sub_reg, sub_next;
    logic [TICKS_W-1:0]        den_reg, den_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [PROD_W-1:0]  acc_reg, acc_next;
    logic [REM_W-1:0]          rem_reg, rem_next;
    logic [REM_W-1:0]          dsh_reg, dsh_next;
    logic [DAC_BITS-1:0]       quo_reg, quo_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      clamp_reg, clamp_next;
    logic                      out_valid_reg, out_valid_next;
    logic [DAC_BITS-1:0]       dac_code_reg, dac_code_next;
    logic                      clamped_reg, clamped_next;

    // ------------------------------------------------------------------
    // Phase step
    // ------------------------------------------------------------------
    logic [PHASE_BITS:0] phase_inc;
    logic [PHASE_BITS:0] phase_wrapped;

    assign phase_inc     = {1'b0, phase_reg} + (PHASE_BITS+1)'(1);
    assign phase_wrapped = (phase_inc > {1'b0, period_reg} || phase_inc[PHASE_BITS])
                         ? (PHASE_BITS+1)'(1) : phase_inc;

    // ------------------------------------------------------------------
    // Operand setup: num = x0*y0 +/- x1*y1 over den
    // ------------------------------------------------------------------
    logic [PHASE_BITS-1:0]  t_val;
    logic                   over_rise;
    logic signed [OP_W-1:0] a_s, off_s, t_s, aoff_s, tmr_s;
    logic signed [OP_W-1:0] den_s;
    logic [TICKS_W-1:0]     den_sel;
    logic signed [OP_W-1:0] sx0, sy0, sx1, sy1;
    logic                   ssub;

    assign t_val     = (phase_reg >= period_reg) ? '0 : phase_reg;
    assign over_rise = (t_val > rise_reg);
    assign a_s       = OP_W'(amplitude_reg);
    assign off_s     = {{(OP_W-OFFS_W){offset_reg[OFFS_W-1]}}, offset_reg};
    assign t_s       = OP_W'(t_val);
    assign aoff_s    = a_s + off_s;
    assign tmr_s     = OP_W'(t_val) - OP_W'(rise_reg);
    assign den_s     = OP_W'(den_sel);

    always_comb
    begin
        // zero divisor: den of one, slope term drops out
        if (wave_mode_reg == MODE_SAWTOOTH)
            den_sel = (period_reg == '0) ? TICKS_W'(1) : period_reg;
        else if (over_rise)
            den_sel = (fall_reg == '0) ? TICKS_W'(1) : fall_reg;
        else
            den_sel = (rise_reg == '0) ? TICKS_W'(1) : rise_reg;

        if (wave_mode_reg != MODE_SAWTOOTH && over_rise)
        begin
            // falling slope: (a+off)*den - a*(t-rise)
            sx0  = aoff_s;
            sy0  = den_s;
            sx1  = (fall_reg == '0) ? '0 : a_s;
            sy1  = tmr_s;
            ssub = 1'b1;
        end
        else
        begin
            // rising slope or sawtooth: a*t + off*den
            sx0  = a_s;
            sy0  = t_s;
            sx1  = off_s;
            sy1  = den_s;
            ssub = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier
    // ------------------------------------------------------------------
    logic signed [OP_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;

    always_comb
    begin
        unique case (state_reg)
            ST_MUL_A:
            begin
                mul_a = x0_reg;
                mul_b = y0_reg;
            end
            ST_MUL_B:
            begin
                mul_a = x1_reg;
                mul_b = y1_reg;
            end
            default:
            begin
                // full-scale divisor VREF_MV * den
                mul_a = OP_W'(den_reg);
                mul_b = OP_W'(VREF_MV);
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // ------------------------------------------------------------------
    // Scale and divide helpers
    // ------------------------------------------------------------------
    logic [PROD_W+DAC_BITS-1:0] scaled;
    logic                       rem_ge;

    // num * DAC_MAX as (num << DAC_BITS) - num
    assign scaled = {acc_reg, {DAC_BITS{1'b0}}}
                  - {{DAC_BITS{acc_reg[PROD_W-1]}}, acc_reg};
    assign rem_ge = (rem_reg >= dsh_reg);

    // ------------------------------------------------------------------
    // Next state and datapath
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        x0_next        = x0_reg;
        y0_next        = y0_reg;
        x1_next        = x1_reg;
        y1_next        = y1_reg;
        sub_next       = sub_reg;
        den_next       = den_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        clamp_next     = clamp_reg;
        dac_code_next  = dac_code_reg;
        clamped_next   = clamped_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && tick)
                begin
                    phase_next = phase_wrapped[PHASE_BITS-1:0];
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                x0_next    = sx0;
                y0_next    = sy0;
                x1_next    = sx1;
                y1_next    = sy1;
                sub_next   = ssub;
                den_next   = den_sel;
                state_next = ST_MUL_A;
            end
            ST_MUL_A:
            begin
                prod_next  = mul_p;
                state_next = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                acc_next   = prod_reg;
                prod_next  = mul_p;
                state_next = ST_MUL_C;
            end
            ST_MUL_C:
            begin
                acc_next   = sub_reg ? (acc_reg - prod_reg) : (acc_reg + prod_reg);
                prod_next  = mul_p;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                // acc = numerator in mV * den, prod = 5000 * den
                if (acc_reg < 0)
                begin
                    quo_next   = '0;
                    clamp_next = 1'b1;
                    state_next = ST_DONE;
                end
                else if (acc_reg > prod_reg)
                begin
                    quo_next   = DAC_BITS'(DAC_MAX);
                    clamp_next = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    rem_next   = scaled[REM_W-1:0];
                    dsh_next   = REM_W'({prod_reg[DIV_W-1:0], {(DAC_BITS-1){1'b0}}});
                    quo_next   = '0;
                    cnt_next   = CNT_W'(DAC_BITS-1);
                    clamp_next = 1'b0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // restoring divide, one quotient bit per cycle, MSB first
                if (rem_ge)
                    rem_next = rem_reg - dsh_reg;
                quo_next = {quo_reg[DAC_BITS-2:0], rem_ge};
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    dac_code_next  = quo_reg;
                    clamped_next   = clamp_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        x0_reg       <= x0_next;
        y0_reg       <= y0_next;
        x1_reg       <= x1_next;
        y1_reg       <= y1_next;
        sub_reg      <= sub_next;
        den_reg      <= den_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        rem_reg      <= rem_next;
        dsh_reg      <= dsh_next;
        quo_reg      <= quo_next;
        cnt_reg      <= cnt_next;
        clamp_reg    <= clamp_next;
        dac_code_reg <= dac_code_next;
        clamped_reg  <= clamped_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign dac_code  = dac_code_reg;
    assign clamped   = clamped_reg;

endmodule

/* verif/wave_sample_checker.sv */
// ----------------------------------------------------------------------------
// wave_sample_checker
// Watches the item, result and APB channels of the wave generator, keeps its
// own phase counter and register copies, predicts each sample and compares.
// ----------------------------------------------------------------------------
module wave_sample_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic                         tick,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [swg_pkg::DAC_BITS-1:0] dac_code,
    input  logic                         clamped,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [swg_pkg::ADDR_W-1:0]   paddr,
    input  logic [swg_pkg::DATA_W-1:0]   pwdata,
    output int                           errors,
    output int                           pending,
    output int                           checked
);
    import swg_pkg::*;

    typedef struct packed {
        logic [DAC_BITS-1:0] code;
        logic                clip;
    } sample_t;

    sample_t expected_samples[$];

    // register copies and phase
    logic [MODE_W-1:0]         mode_r;
    logic [TICKS_W-1:0]        period_r;
    logic [AMP_W-1:0]          amp_r;
    logic signed [OFFS_W-1:0]  offs_r;
    logic [TICKS_W-1:0]        rise_r;
    logic [TICKS_W-1:0]        fall_r;
    logic [PHASE_BITS-1:0]     phase_r;

    logic [PHASE_BITS:0]       next_phase;
    longint                    t_now;
    sample_t                   want;

    task automatic report_mismatch(input string what, input int got, input int want_v);
        errors++;
        $display("mismatch at result %0d: %s = %0d, expected %0d",
                 checked, what, got, want_v);
    endtask

    // exact fraction num/den in mV, then clamp and truncating scale
    function automatic sample_t wave_sample(input longint t);
        longint a, off, num, den;
        sample_t s;
        a   = longint'(amp_r);
        off = longint'(offs_r);
        if (mode_r == MODE_SAWTOOTH)
        begin
            if (period_r == 0)
            begin
                num = off;
                den = 1;
            end
            else
            begin
                den = longint'(period_r);
                num = a * t + off * den;
            end
        end
        else if (t > longint'(rise_r))
        begin
            if (fall_r == 0)
            begin
                num = a + off;
                den = 1;
            end
            else
            begin
                den = longint'(fall_r);
                num = (a + off) * den - a * (t - longint'(rise_r));
            end
        end
        else
        begin
            if (rise_r == 0)
            begin
                num = off;
                den = 1;
            end
            else
            begin
                den = longint'(rise_r);
                num = a * t + off * den;
            end
        end
        if (num < 0)
        begin
            s.code = '0;
            s.clip = 1'b1;
        end
        else if (num > longint'(VREF_MV) * den)
        begin
            s.code = DAC_BITS'(DAC_MAX);
            s.clip = 1'b1;
        end
        else
        begin
            s.code = DAC_BITS'((num * DAC_MAX) / (longint'(VREF_MV) * den));
            s.clip = 1'b0;
        end
        return s;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_r   = RST_WAVE_MODE;
            period_r = RST_PERIOD;
            amp_r    = RST_AMPLITUDE;
            offs_r   = RST_OFFSET;
            rise_r   = RST_RISE;
            fall_r   = RST_FALL;
            phase_r  = '0;
            expected_samples.delete();
            errors   = 0;
            pending  = 0;
            checked  = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_samples.size() == 0)
                begin
                    report_mismatch("dac_code with no sample due", int'(dac_code), -1);
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (dac_code !== want.code)
                        report_mismatch("dac_code", int'(dac_code), int'(want.code));
                    if (clamped !== want.clip)
                        report_mismatch("clamped", int'(clamped), int'(want.clip));
                    checked++;
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[4:2]))
                    REG_WAVE_MODE:    mode_r   = pwdata[MODE_W-1:0];
                    REG_PERIOD_TICKS: period_r = pwdata[TICKS_W-1:0];
                    REG_AMPLITUDE_MV: amp_r    = pwdata[AMP_W-1:0];
                    REG_OFFSET_MV:    offs_r   = pwdata[OFFS_W-1:0];
                    REG_RISE_TICKS:   rise_r   = pwdata[TICKS_W-1:0];
                    REG_FALL_TICKS:   fall_r   = pwdata[TICKS_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall && tick)
            begin
                next_phase = {1'b0, phase_r} + (PHASE_BITS+1)'(1);
                if (next_phase > {1'b0, period_r} || next_phase[PHASE_BITS])
                    next_phase = (PHASE_BITS+1)'(1);
                phase_r = next_phase[PHASE_BITS-1:0];
                t_now = (phase_r >= period_r) ? 0 : longint'(phase_r);
                expected_samples.push_back(wave_sample(t_now));
            end
            pending = expected_samples.size();
        end
    end

endmodule

/* verif/sawtooth_triangle_wave_generator_tb.sv */
// ----------------------------------------------------------------------------
// sawtooth_triangle_wave_generator_tb
// Drives tick items and APB register writes into the wave generator with
// random gaps and output stalls; a separate checker predicts every sample.
// ----------------------------------------------------------------------------
module sawtooth_triangle_wave_generator_tb;
    import swg_pkg::*;

    // triangle is the only other mode besides sawtooth
    localparam logic [MODE_W-1:0] MODE_TRIANGLE = 1'b1;

    // idle cycles allowed for the block to drain before a register write
    localparam int SETTLE_CYCLES = 32;
    // cycles with no handshake at all before the run is declared hung
    localparam int HANG_LIMIT    = 4000;
    localparam int RAND_PHASES   = 12;
    localparam int PHASE_ITEMS   = 50;

    typedef struct {
        logic [MODE_W-1:0]        mode;
        logic [TICKS_W-1:0]       period;
        logic [AMP_W-1:0]         amp;
        logic signed [OFFS_W-1:0] offs;
        logic [TICKS_W-1:0]       rise;
        logic [TICKS_W-1:0]       fall;
    } wave_cfg_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 tick;
    logic                 out_valid;
    logic                 out_stall;
    logic [DAC_BITS-1:0]  dac_code;
    logic                 clamped;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [DATA_W-1:0]    pwdata;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    int errors;
    int pending;
    int checked;

    // run bookkeeping for the summary
    int n_items;
    int n_no_tick;
    int n_settings;
    int quiet_cycles;

    // when set, both sides run back to back with no idling
    bit steady;

    sawtooth_triangle_wave_generator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .tick      (tick),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dac_code  (dac_code),
        .clamped   (clamped),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    wave_sample_checker u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .tick      (tick),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dac_code  (dac_code),
        .clamped   (clamped),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .pready    (pready),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Wait draw shared by both sides: zero a good part of the time so that
    // back-to-back traffic shows up, otherwise anywhere in 0..15.
    function automatic int draw_wait();
        if (steady || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 15);
    endfunction

    // Hang watchdog: any accepted item, result or register write resets it.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (psel && penable && pwrite && pready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= HANG_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles, %0d samples due",
                         HANG_LIMIT, pending);
                $display("** sawtooth_triangle_wave_generator: FAILED **");
                $finish;
            end
        end
    end

    // Result side: before each result, hold stall for a drawn number of
    // cycles, then drop it and take whatever result comes next.
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            n = draw_wait();
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
        end
    end

    // One item on the input channel. Called and returning at a falling edge;
    // valid stays up on return so a zero gap keeps the channel busy.
    task automatic send_item(input logic t);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        tick     <= t;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        n_items++;
        if (!t)
            n_no_tick++;
    endtask

    // APB write: setup phase, access phase, then back to idle with psel low.
    task automatic apb_write(input reg_idx_t idx, input logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Drop valid, let every due sample come out, then give the block time
    // to finish a tick-less item or an in-flight sample.
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apply_settings(input wave_cfg_t c);
        apb_write(REG_WAVE_MODE,    DATA_W'(c.mode));
        apb_write(REG_PERIOD_TICKS, DATA_W'(c.period));
        apb_write(REG_AMPLITUDE_MV, DATA_W'(c.amp));
        apb_write(REG_OFFSET_MV,    {{(DATA_W-OFFS_W){1'b0}}, c.offs});
        apb_write(REG_RISE_TICKS,   DATA_W'(c.rise));
        apb_write(REG_FALL_TICKS,   DATA_W'(c.fall));
        n_settings++;
    endtask

    function automatic wave_cfg_t make_cfg(input logic [MODE_W-1:0] mode, input int period,
                                           input int amp, input int offs,
                                           input int rise, input int fall);
        wave_cfg_t c;
        c.mode   = mode;
        c.period = TICKS_W'(period);
        c.amp    = AMP_W'(amp);
        c.offs   = OFFS_W'(offs);
        c.rise   = TICKS_W'(rise);
        c.fall   = TICKS_W'(fall);
        return c;
    endfunction

    // Tick counts: mostly short so the phase wraps often, now and then long.
    function automatic int pick_ticks();
        case ($urandom_range(0, 9))
            0:       return 1;
            1:       return 65535;
            2, 3:    return $urandom_range(41, 3000);
            default: return $urandom_range(1, 40);
        endcase
    endfunction

    function automatic wave_cfg_t pick_cfg(input int ph);
        wave_cfg_t c;
        int amp;
        int offs;
        case ($urandom_range(0, 4))
            0:       amp = 0;
            1:       amp = 9999;
            default: amp = $urandom_range(0, 9999);
        endcase
        case ($urandom_range(0, 4))
            0:       offs = -9999;
            1:       offs = 9999;
            default: offs = int'($urandom_range(0, 19998)) - 9999;
        endcase
        c = make_cfg(MODE_W'($urandom_range(0, 1)), pick_ticks(), amp, offs,
                     pick_ticks(), pick_ticks());
        // first two random phases sit at the top and bottom of every range
        if (ph == 0)
            c = make_cfg(MODE_TRIANGLE, 65535, 9999, 9999, 65535, 65535);
        else if (ph == 1)
            c = make_cfg(MODE_SAWTOOTH, 1, 0, -9999, 1, 1);
        return c;
    endfunction

    task automatic run_directed(input wave_cfg_t c, input int n);
        settle();
        apply_settings(c);
        repeat (n) send_item(1'b1);
    endtask

    initial
    begin
        wave_cfg_t c;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        tick      = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        steady    = 1'b0;
        n_items   = 0;
        n_no_tick = 0;
        n_settings = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed ----
        // reset settings, with a tick-less item in between (no result)
        send_item(1'b1);
        send_item(1'b0);
        send_item(1'b1);
        // upper clamp
        run_directed(make_cfg(MODE_SAWTOOTH, 3, 9999, 9999, 1500, 1500), 2);
        // lower clamp in sawtooth
        run_directed(make_cfg(MODE_SAWTOOTH, 2, 0, -9999, 1500, 1500), 1);
        // phase lands on the period: t = 0, value exactly 0 mV, not clamped
        run_directed(make_cfg(MODE_SAWTOOTH, 1, 5000, 0, 1500, 1500), 1);
        // exactly 5000 mV, not clamped
        run_directed(make_cfg(MODE_SAWTOOTH, 2, 0, 5000, 1500, 1500), 1);
        // triangle with period past rise + fall: drops below 0 mV
        run_directed(make_cfg(MODE_TRIANGLE, 8, 4000, 100, 2, 3), 8);
        // zero period divisor
        run_directed(make_cfg(MODE_SAWTOOTH, 0, 2500, 700, 1500, 1500), 1);
        // zero rise at t = 0, then zero fall
        run_directed(make_cfg(MODE_TRIANGLE, 2, 1234, 50, 0, 0), 3);
        // full register widths
        run_directed(make_cfg(MODE_SAWTOOTH, 65535, 16383, -16384, 65535, 65535), 1);
        run_directed(make_cfg(MODE_TRIANGLE, 65535, 16383, 16383, 65535, 65535), 1);

        // ---- random ----
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            c = pick_cfg(ph);
            settle();
            steady = (ph % 4 == 3);
            apply_settings(c);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // sender holds off until the block has drained completely
                if (ph == 5 && i == PHASE_ITEMS / 2)
                begin
                    in_valid <= 1'b0;
                    @(negedge clk);
                    while (pending != 0)
                        @(negedge clk);
                end
                send_item($urandom_range(0, 7) != 0);
            end
        end
        steady = 1'b0;

        // ---- drain and verdict ----
        settle();
        $display("run covered %0d items (%0d without tick), %0d register settings",
                 n_items, n_no_tick, n_settings);
        $display("%0d samples checked across both wave modes, %0d mismatches",
                 checked, errors);
        if (errors == 0)
            $display("** sawtooth_triangle_wave_generator: PASSED **");
        else
            $display("** sawtooth_triangle_wave_generator: FAILED **");
        $finish;
    end

endmodule
